>>> rtl/gf2m_add_mul_div_unit_macros.svh
// ----------------------------------------------------------------------------
// GF(2^m) unit assertion macros
// Shared concurrent assertion forms for the checkers of the field unit.
// ----------------------------------------------------------------------------
`ifndef GF2M_ADD_MUL_DIV_UNIT_MACROS_SVH
`define GF2M_ADD_MUL_DIV_UNIT_MACROS_SVH

// Overlapped implication; the consequent may carry its own cycle delay.
`define GFAMDU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("gf2m unit check failed");

// Non-overlapped implication, checked in the following cycle.
`define GFAMDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gf2m unit check failed");

`endif

>>> rtl/gfamdu_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^m) unit package
// Widths, request codes, the pipeline item type and field arithmetic helpers.
// ----------------------------------------------------------------------------
package gfamdu_pkg;

  localparam int MaxDegree = 8;
  localparam int ElemW     = MaxDegree;
  localparam int PolyW     = MaxDegree + 1;
  localparam int DegW      = $clog2(MaxDegree + 1);
  localparam int StepW     = $clog2(MaxDegree);
  localparam int ReqW      = 2;
  // Edges from the accepting edge to the edge that takes the result.
  localparam int Latency   = MaxDegree + 2;

  localparam logic [ReqW-1:0] ReqAdd = 2'd0;
  localparam logic [ReqW-1:0] ReqMul = 2'd1;
  localparam logic [ReqW-1:0] ReqDiv = 2'd2;

  localparam logic [PolyW-1:0] PolyReset = PolyW'(285);

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [PolyW-1:0] poly_t;
  typedef logic [DegW-1:0]  deg_t;

  // One request as it travels down the exponentiation chain.
  typedef struct packed {
    logic [ReqW-1:0] kind;
    elem_t           a;
    elem_t           base;
    elem_t           acc;
    elem_t           early;
    logic            err;
  } item_t;

  // Degree of the field polynomial: position of its highest set bit.
  function automatic deg_t poly_degree(poly_t p);
    deg_t d;
    d = '0;
    for (int i = 1; i <= MaxDegree; i++) begin
      if (p[i]) d = DegW'(i);
    end
    return d;
  endfunction

  // Mask of the element bits below the degree.
  function automatic elem_t field_mask(deg_t d);
    elem_t m;
    for (int j = 0; j < ElemW; j++) begin
      m[j] = (DegW'(j) < d);
    end
    return m;
  endfunction

  // Shift-and-add product reduced by the field polynomial, MSB of b first.
  function automatic elem_t gf_mul(elem_t a, elem_t b, poly_t p, deg_t d);
    poly_t r;
    poly_t top;
    r   = '0;
    top = poly_t'(1) << d;
    for (int i = ElemW - 1; i >= 0; i--) begin
      if (DegW'(i) < d) begin
        r = r << 1;
        if ((r & top) != '0) r = r ^ p;
        if (b[i]) r = r ^ {1'b0, a};
      end
    end
    return r[ElemW-1:0];
  endfunction

endpackage

>>> rtl/gfamdu_cell.sv
// ----------------------------------------------------------------------------
// GF(2^m) exponentiation cell
// One square-and-multiply step of the divisor inversion, registered.
// ----------------------------------------------------------------------------
module gfamdu_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [gfamdu_pkg::StepW-1:0]     cell_index,
  input  gfamdu_pkg::poly_t                poly,
  input  gfamdu_pkg::deg_t                 deg,
  input  logic                             valid_in,
  input  gfamdu_pkg::item_t                item_in,
  output logic                             valid_out,
  output gfamdu_pkg::item_t                item_out
);

  // Exponent 2^m - 2 has every bit set from bit 1 up to bit m - 1.
  logic exp_bit;
  assign exp_bit = (cell_index != '0) && ({1'b0, cell_index} < deg);

  // Step and squaring both work on the registered base.
  gfamdu_pkg::item_t item_next;
  always_comb begin
    item_next      = item_in;
    item_next.base = gfamdu_pkg::gf_mul(item_in.base, item_in.base, poly, deg);
    if (exp_bit) begin
      item_next.acc = gfamdu_pkg::gf_mul(item_in.acc, item_in.base, poly, deg);
    end
  end

  // Valid flag under reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    item_out <= item_next;
  end

endmodule

>>> rtl/gfamdu_out.sv
// ----------------------------------------------------------------------------
// GF(2^m) result stage
// Finishes a divide with the last product and registers the result strobe.
// ----------------------------------------------------------------------------
module gfamdu_out (
  input  logic                           clk,
  input  logic                           rst,
  input  gfamdu_pkg::poly_t              poly,
  input  gfamdu_pkg::deg_t               deg,
  input  logic                           valid_in,
  input  gfamdu_pkg::item_t              item_in,
  output logic                           result_valid,
  output logic [gfamdu_pkg::ElemW-1:0]   field_result,
  output logic                           div_zero_error
);

  // A divide multiplies the dividend by the inverse; others pass through.
  gfamdu_pkg::elem_t result_next;
  always_comb begin
    if ((item_in.kind == gfamdu_pkg::ReqDiv) && !item_in.err) begin
      result_next = gfamdu_pkg::gf_mul(item_in.a, item_in.acc, poly, deg);
    end else begin
      result_next = item_in.early;
    end
  end

  // Strobe under reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= valid_in;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    field_result   <= result_next;
    div_zero_error <= item_in.err;
  end

endmodule

>>> rtl/gf2m_add_mul_div_unit.sv
// ----------------------------------------------------------------------------
// GF(2^m) add / multiply / divide unit
// Pipelined field arithmetic with a chain of square-and-multiply cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, operand_a, operand_b) transfers at a rising edge
//   with start high and busy low. busy is always low, so one request can
//   transfer in every cycle.
//   Each request yields one result on field_result and div_zero_error,
//   shown for exactly one cycle with result_valid high. The result transfers
//   at the edge that ends that cycle, after the request has passed the input
//   register, eight inversion cells and the result register. Results come
//   out in request order at one per cycle; the receiver cannot stall them.
//   The inversion raises the divisor to 2^m - 2 through the cell chain, one
//   cell per exponent bit, so the latency follows the maximum degree.
//   The field polynomial is written through cfg_valid / cfg_ready /
//   cfg_field_poly. cfg_ready is high only while no request is in flight
//   and start is low.
//   Reset clears the pipeline and loads the polynomial 0x11D.
// ----------------------------------------------------------------------------
module gf2m_add_mul_div_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gfamdu_pkg::ReqW-1:0]         req_type,
  input  logic [gfamdu_pkg::ElemW-1:0]        operand_a,
  input  logic [gfamdu_pkg::ElemW-1:0]        operand_b,
  output logic                                result_valid,
  output logic [gfamdu_pkg::ElemW-1:0]        field_result,
  output logic                                div_zero_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gfamdu_pkg::PolyW-1:0]        cfg_field_poly
);

  gfamdu_pkg::poly_t poly;
  gfamdu_pkg::deg_t  deg;

  logic [gfamdu_pkg::MaxDegree:0] stage_valid;
  gfamdu_pkg::item_t              stage_item [0:gfamdu_pkg::MaxDegree];

  logic              front_valid;
  gfamdu_pkg::item_t front_item;
  gfamdu_pkg::item_t front_next;

  logic accept;

  // The unit takes a request in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Polynomial writes only land while the pipeline is empty.
  assign cfg_ready = !start && (stage_valid == '0) && !result_valid;

  // Field polynomial register and its degree.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= gfamdu_pkg::PolyReset;
      deg  <= gfamdu_pkg::poly_degree(gfamdu_pkg::PolyReset);
    end else if (cfg_valid && cfg_ready) begin
      poly <= cfg_field_poly;
      deg  <= gfamdu_pkg::poly_degree(cfg_field_poly);
    end
  end

  // Operand masking, add and multiply results, and the divide-by-zero check.
  always_comb begin
    gfamdu_pkg::elem_t mask;
    mask            = gfamdu_pkg::field_mask(deg);
    front_next.kind = req_type;
    front_next.a    = operand_a & mask;
    front_next.base = operand_b & mask;
    front_next.acc  = gfamdu_pkg::ElemW'(1);
    front_next.err  = (req_type == gfamdu_pkg::ReqDiv) && (front_next.base == '0);
    case (req_type)
      gfamdu_pkg::ReqAdd: front_next.early = front_next.a ^ front_next.base;
      gfamdu_pkg::ReqMul: front_next.early =
        gfamdu_pkg::gf_mul(front_next.a, front_next.base, poly, deg);
      default:            front_next.early = '0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    front_item <= front_next;
  end

  assign stage_valid[0] = front_valid;
  assign stage_item[0]  = front_item;

  // Chain of inversion cells, one per exponent bit.
  for (genvar k = 0; k < gfamdu_pkg::MaxDegree; k++) begin : g_cell
    gfamdu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (gfamdu_pkg::StepW'(k)),
      .poly       (poly),
      .deg        (deg),
      .valid_in   (stage_valid[k]),
      .item_in    (stage_item[k]),
      .valid_out  (stage_valid[k+1]),
      .item_out   (stage_item[k+1])
    );
  end

  // Final product and result register.
  gfamdu_out u_out (
    .clk            (clk),
    .rst            (rst),
    .poly           (poly),
    .deg            (deg),
    .valid_in       (stage_valid[gfamdu_pkg::MaxDegree]),
    .item_in        (stage_item[gfamdu_pkg::MaxDegree]),
    .result_valid   (result_valid),
    .field_result   (field_result),
    .div_zero_error (div_zero_error)
  );

endmodule

>>> rtl/gfamdu_checker.sv
// ----------------------------------------------------------------------------
// GF(2^m) unit port checker
// Timing and divide-by-zero checks on the ports of the field unit.
// ----------------------------------------------------------------------------
`include "gf2m_add_mul_div_unit_macros.svh"

module gfamdu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [gfamdu_pkg::ReqW-1:0]         req_type,
  input logic [gfamdu_pkg::ElemW-1:0]        operand_b,
  input logic                                result_valid,
  input logic [gfamdu_pkg::ElemW-1:0]        field_result,
  input logic                                div_zero_error,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  logic accept;
  assign accept = start && !busy;

  // A divide transfer with a raw zero divisor, and the result it must give.
  logic div_by_zero;
  logic zero_flagged;
  assign div_by_zero  = accept && (req_type == gfamdu_pkg::ReqDiv) && (operand_b == '0);
  assign zero_flagged = div_zero_error && (field_result == '0);

  // Every transfer gives exactly one strobe after the fixed latency.
  `GFAMDU_ASSERT_IMPL(a_result_follows, clk, rst, accept, ##(gfamdu_pkg::Latency) result_valid)
  `GFAMDU_ASSERT_IMPL(a_no_spurious, clk, rst, !accept, ##(gfamdu_pkg::Latency) !result_valid)

  // A zero divisor gives a zero result with the error flag.
  `GFAMDU_ASSERT_IMPL(a_div_zero, clk, rst, div_by_zero, ##(gfamdu_pkg::Latency) zero_flagged)

  // A polynomial write only happens with nothing in flight.
  `GFAMDU_ASSERT_NEXT(a_cfg_idle, clk, rst, cfg_valid && cfg_ready, !result_valid)

endmodule

bind gf2m_add_mul_div_unit gfamdu_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .req_type       (req_type),
  .operand_b      (operand_b),
  .result_valid   (result_valid),
  .field_result   (field_result),
  .div_zero_error (div_zero_error),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// GF(2^m) add / multiply / divide unit testbench
// Sends field requests through the start/busy command port, predicts each
// result with an independent software field model that tracks the field
// polynomial register, and checks every result strobe in order. The run
// covers the reset polynomial, degenerate and reducible polynomials, and
// random traffic with random sender idling.
// ----------------------------------------------------------------------------
module testbench;
  import gfamdu_pkg::*;

  // Request code that the block does not define; it must give an all-zero result.
  localparam logic [ReqW-1:0] ReqSpare = 2'd3;

  localparam int ResetCycles   = 7;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseCount    = 20;
  localparam int PhaseItems    = 100;
  localparam int FixedPolys    = 14;

  typedef struct packed {
    elem_t value;
    logic  div_zero;
  } field_outcome_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [ReqW-1:0] req_type;
  elem_t           operand_a;
  elem_t           operand_b;
  logic            result_valid;
  elem_t           field_result;
  logic            div_zero_error;
  logic            cfg_valid;
  logic            cfg_ready;
  poly_t           cfg_field_poly;

  // Mirror of the field polynomial register and the results still owed.
  poly_t          field_poly_model;
  field_outcome_t pending_results[$];
  bit             idle_enable;

  int n_errors;
  int n_requests;
  int n_results;
  int n_div_zero;
  int n_poly_writes;
  int quiet_cycles;

  gf2m_add_mul_div_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .result_valid   (result_valid),
    .field_result   (field_result),
    .div_zero_error (div_zero_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_field_poly (cfg_field_poly)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Field model
  // ---------------------------------------------------------------------------

  // The degree is the highest set bit of the polynomial, ignoring bit 0.
  function automatic int field_degree(poly_t p);
    int d;
    d = 0;
    for (int i = 1; i < PolyW; i++) begin
      if (p[i]) d = i;
    end
    return d;
  endfunction

  function automatic elem_t elem_mask(int d);
    logic [15:0] m;
    m = (16'd1 << d) - 16'd1;
    return m[ElemW-1:0];
  endfunction

  // Carry-less product followed by long division by the polynomial.
  function automatic elem_t field_product(elem_t a, elem_t b, poly_t p, int d);
    logic [15:0] prod;
    prod = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (b[i]) prod = prod ^ (16'(a) << i);
    end
    if (d > 0) begin
      for (int i = 15; i >= d; i--) begin
        if (prod[i]) prod = prod ^ (16'(p) << (i - d));
      end
    end
    return prod[ElemW-1:0] & elem_mask(d);
  endfunction

  // Square-and-multiply power; with exponent 2^m - 2 this is the inverse.
  function automatic elem_t field_power(elem_t base, int e, poly_t p, int d);
    elem_t acc;
    acc = 8'd1;
    while (e != 0) begin
      if (e[0]) acc = field_product(acc, base, p, d);
      base = field_product(base, base, p, d);
      e = e >> 1;
    end
    return acc & elem_mask(d);
  endfunction

  function automatic field_outcome_t predict_field_op(logic [ReqW-1:0] kind, elem_t a_in,
                                                      elem_t b_in, poly_t p);
    field_outcome_t r;
    int             d;
    elem_t          a;
    elem_t          b;
    d = field_degree(p);
    a = a_in & elem_mask(d);
    b = b_in & elem_mask(d);
    r = '0;
    case (kind)
      ReqAdd: begin
        r.value = a ^ b;
      end
      ReqMul: begin
        r.value = field_product(a, b, p, d);
      end
      ReqDiv: begin
        if (b == '0) begin
          r.div_zero = 1'b1;
        end else begin
          r.value = field_product(a, field_power(b, (1 << d) - 2, p, d), p, d);
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Operands lean toward zero, all ones, one and single bits.
  function automatic elem_t pick_elem();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'h01 << $urandom_range(0, 7);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) return ReqAdd;
    if (r < 10) return ReqMul;
    if (r < 15) return ReqDiv;
    return ReqSpare;
  endfunction

  // Drop start for a random burst while noise sits on the request fields.
  task automatic idle_burst();
    start     <= 1'b0;
    req_type  <= ReqW'($urandom);
    operand_a <= elem_t'($urandom);
    operand_b <= elem_t'($urandom);
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  // Present one request and hold it until it transfers.
  task automatic send_request(logic [ReqW-1:0] kind, elem_t a, elem_t b);
    field_outcome_t r;
    start     <= 1'b1;
    req_type  <= kind;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    r = predict_field_op(kind, a, b, field_poly_model);
    pending_results.push_back(r);
    n_requests++;
    if (r.div_zero) n_div_zero++;
    if (idle_enable && ($urandom_range(0, 7) == 0)) idle_burst();
  endtask

  // The polynomial is only written with the pipeline drained.
  task automatic write_field_poly(poly_t value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_field_poly <= value;
    do @(posedge clk); while (!cfg_ready);
    field_poly_model = value;
    n_poly_writes++;
    cfg_valid      <= 1'b0;
    cfg_field_poly <= poly_t'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operand extremes, zero operands, divide by zero and the spare request code on the reset polynomial.
  task automatic test_reset_polynomial();
    send_request(ReqAdd, 8'hFF, 8'h00);
    send_request(ReqAdd, 8'hFF, 8'hFF);
    send_request(ReqMul, 8'h00, 8'h53);
    send_request(ReqMul, 8'h53, 8'h00);
    send_request(ReqMul, 8'hFF, 8'hFF);
    send_request(ReqMul, 8'h80, 8'h02);
    send_request(ReqDiv, 8'h53, 8'h00);
    send_request(ReqDiv, 8'h00, 8'h53);
    send_request(ReqDiv, 8'hFF, 8'hFF);
    send_request(ReqDiv, 8'h01, 8'h02);
    send_request(ReqDiv, 8'h80, 8'h01);
    send_request(ReqSpare, 8'hFF, 8'hFF);
  endtask

  // Degenerate, low-degree and reducible polynomials, including the extremes.
  task automatic test_polynomial_corners();
    poly_t corners[5];
    corners = '{9'h000, 9'h001, 9'h00B, 9'h010, 9'h1FF};
    foreach (corners[i]) begin
      write_field_poly(corners[i]);
      // The divisor has only high bits, so it masks to zero on small fields.
      send_request(ReqDiv, 8'hFF, 8'hF0);
      send_request(ReqMul, 8'hFF, 8'hFF);
    end
  endtask

  // Random traffic over a series of polynomial settings.
  task automatic test_random_traffic();
    poly_t fixed_polys[FixedPolys];
    poly_t p;
    fixed_polys = '{PolyReset, 9'h013, 9'h025, 9'h043, 9'h089, 9'h11B, 9'h1FF,
                    9'h010, 9'h000, 9'h001, 9'h003, 9'h00B, 9'h100, 9'h1F5};
    for (int ph = 0; ph < PhaseCount; ph++) begin
      p = (ph < FixedPolys) ? fixed_polys[ph] : poly_t'($urandom_range(0, 511));
      write_field_poly(p);
      // The closing phases run back to back with no idling.
      idle_enable = (ph < PhaseCount - 2);
      for (int n = 0; n < PhaseItems; n++) begin
        send_request(pick_kind(), pick_elem(), pick_elem());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: each strobe is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    field_outcome_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding: field_result=%0h", field_result);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (field_result !== want.value) begin
          $error("field_result mismatch: expected %0h, actual %0h", want.value, field_result);
          n_errors++;
        end
        if (div_zero_error !== want.div_zero) begin
          $error("div_zero_error mismatch: expected %0b, actual %0b",
                 want.div_zero, div_zero_error);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    n_errors         = 0;
    n_requests       = 0;
    n_results        = 0;
    n_div_zero       = 0;
    n_poly_writes    = 0;
    quiet_cycles     = 0;
    idle_enable      = 1'b1;
    field_poly_model = PolyReset;
    rst            <= 1'b1;
    start          <= 1'b0;
    req_type       <= ReqAdd;
    operand_a      <= '0;
    operand_b      <= '0;
    cfg_valid      <= 1'b0;
    cfg_field_poly <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_polynomial();
    test_polynomial_corners();
    test_random_traffic();

    // Drain the pipeline, then give any stray result time to show up.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);

    $display("Checked %0d results from %0d requests (%0d divide by zero) over %0d polynomial writes.",
             n_results, n_requests, n_div_zero, n_poly_writes);
    $display("Polynomials ranged from degree 0 to 8, including reducible ones.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
